[design/stpg_pkg.sv]
// Package for the sensor test pattern generator.
// Holds field widths, codes, state and operation types and the structs shared between the modules.
// Depends on nothing.
`timescale 1ns / 1ps

package stpg_pkg;

    localparam int ACTION_W    = 2;
    localparam int WORD_W      = 32;
    localparam int MODE_W      = 3;
    localparam int PERIOD_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int UNIT_STEPS  = 32;
    localparam int UNIT_CNT_W  = 6;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_CONST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RAND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THIRD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Multiplying by this and dropping 35 bits divides any 32-bit unsigned value by ten.
    localparam logic [WORD_W-1:0]   RECIP_TEN    = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP1,
        ST_OP2,
        ST_SUM,
        ST_FINISH,
        ST_EMIT
    } stpg_state_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } stpg_op_t;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [WORD_W-1:0]   first;
        logic signed [WORD_W-1:0]   second;
        logic signed [WORD_W-1:0]   third;
        logic [PERIOD_W-1:0]        period;
    } stpg_cfg_t;

    typedef struct packed {
        logic               start;
        stpg_op_t           op;
        logic [WORD_W-1:0]  opa;
        logic [WORD_W-1:0]  opb;
    } stpg_unit_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [WORD_W-1:0]  hi;
        logic [WORD_W-1:0]  lo;
    } stpg_unit_resp_t;

endpackage

[design/stpg_in_if.sv]
// Input item channel of the sensor test pattern generator.
// Depends on stpg_pkg.
`timescale 1ns / 1ps

interface stpg_in_if;
    logic                               valid;
    logic                               ready;
    logic [stpg_pkg::ACTION_W-1:0]      action;
    logic [stpg_pkg::WORD_W-1:0]        random_word;

    modport source (output valid, output action, output random_word, input ready);
    modport sink (input valid, input action, input random_word, output ready);
endinterface

[design/stpg_out_if.sv]
// Result item channel of the sensor test pattern generator.
// Depends on stpg_pkg.
`timescale 1ns / 1ps

interface stpg_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [stpg_pkg::WORD_W-1:0] sample;
    logic                               sample_valid;
    logic                               sample_ready;
    logic                               running;
    logic [stpg_pkg::WORD_W-1:0]        sample_number;

    modport source (output valid, output sample, output sample_valid, output sample_ready,
                    output running, output sample_number, input ready);
    modport sink (input valid, input sample, input sample_valid, input sample_ready,
                  input running, input sample_number, output ready);
endinterface

[design/stpg_cfg_if.sv]
// Configuration write channel of the sensor test pattern generator.
// Depends on stpg_pkg.
`timescale 1ns / 1ps

interface stpg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [stpg_pkg::CFG_INDEX_W-1:0]   index;
    logic [stpg_pkg::WORD_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/sensor_test_pattern_generator_unit.sv]
// Top level of the sensor test pattern generator.
// Depends on stpg_pkg, the three channel interfaces, stpg_cfg_regs, stpg_iter_unit, stpg_core.
//
//  Channel  Role    Payload
//  item     sink    action, random_word
//  result   source  sample, sample_valid, sample_ready, running, sample_number
//  cfg      sink    index, data (always ready)
//
// Ticks, starts, no-ops and reads while idle go from transfer through the emit state to the result.
// Ramp reads make one 32-step multiply in the shared unit.
// Constant and random reads make two 32-step passes through the shared unit,
// where the scaling by ten is a reciprocal multiply and the random offset a division.
// The next item transfers while a result waits in the output register.
// Reset is asynchronous and active low; there is no clearing pass.
`timescale 1ns / 1ps

module sensor_test_pattern_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    stpg_cfg_if.sink    cfg,
    stpg_in_if.sink     item,
    stpg_out_if.source  result
);

    stpg_pkg::stpg_cfg_t        cfg_regs;
    stpg_pkg::stpg_unit_req_t   unit_req;
    stpg_pkg::stpg_unit_resp_t  unit_resp;

    stpg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    stpg_iter_unit u_iter_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .resp  (unit_resp)
    );

    stpg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_regs),
        .item      (item),
        .result    (result),
        .unit_req  (unit_req),
        .unit_resp (unit_resp)
    );

`ifndef ASSERT_OFF
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        unit_req.start |-> !unit_resp.busy)
        else $error("Shared unit started while busy.");

    a_no_transfer_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        unit_resp.busy |-> !item.ready)
        else $error("Input ready while the shared unit is busy.");

    a_valid_sample_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.sample_valid) |-> (result.running && !result.sample_ready))
        else $error("Valid sample with inconsistent status.");
`endif

endmodule

[design/stpg_cfg_regs.sv]
// Configuration register file: decodes write transfers into the five pattern registers.
// Depends on stpg_pkg and stpg_cfg_if.
`timescale 1ns / 1ps

module stpg_cfg_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    stpg_cfg_if.sink                cfg,
    output stpg_pkg::stpg_cfg_t     regs
);

    stpg_pkg::stpg_cfg_t regs_reg;
    stpg_pkg::stpg_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                stpg_pkg::CFG_MODE:   regs_next.mode   = cfg.data[stpg_pkg::MODE_W-1:0];
                stpg_pkg::CFG_FIRST:  regs_next.first  = $signed(cfg.data);
                stpg_pkg::CFG_SECOND: regs_next.second = $signed(cfg.data);
                stpg_pkg::CFG_THIRD:  regs_next.third  = $signed(cfg.data);
                stpg_pkg::CFG_PERIOD: regs_next.period = cfg.data[stpg_pkg::PERIOD_W-1:0];
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mode   <= stpg_pkg::MODE_NONE;
            regs_reg.first  <= '0;
            regs_reg.second <= '0;
            regs_reg.third  <= '0;
            regs_reg.period <= stpg_pkg::PERIOD_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[design/stpg_iter_unit.sv]
// Shared iterative unit: unsigned 32-bit restoring division or shift-add multiplication,
// one bit per cycle through one adder. Depends on stpg_pkg.
`timescale 1ns / 1ps

module stpg_iter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stpg_pkg::stpg_unit_req_t    req,
    output stpg_pkg::stpg_unit_resp_t   resp
);

    localparam int ADD_W = stpg_pkg::WORD_W + 2;

    logic [stpg_pkg::WORD_W-1:0]    h_reg, h_next;
    logic [stpg_pkg::WORD_W-1:0]    l_reg, l_next;
    logic [stpg_pkg::WORD_W-1:0]    d_reg, d_next;
    stpg_pkg::stpg_op_t             op_reg, op_next;
    logic [stpg_pkg::UNIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [stpg_pkg::WORD_W:0]      trial;
    logic [ADD_W-1:0]               add_x;
    logic [ADD_W-1:0]               add_y;
    logic [ADD_W-1:0]               add_sum;
    logic                           add_cin;

    assign resp.busy = busy_reg;
    assign resp.done = done_reg;
    assign resp.hi   = h_reg;
    assign resp.lo   = l_reg;

    assign trial = {h_reg, l_reg[stpg_pkg::WORD_W-1]};

    always_comb
    begin
        if (op_reg == stpg_pkg::OP_DIV)
        begin
            add_x   = {1'b0, trial};
            add_y   = ~{2'b00, d_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = {2'b00, h_reg};
            add_y   = l_reg[0] ? {2'b00, d_reg} : '0;
            add_cin = 1'b0;
        end
        add_sum = add_x + add_y + {{(ADD_W-1){1'b0}}, add_cin};
    end

    always_comb
    begin
        h_next    = h_reg;
        l_next    = l_reg;
        d_next    = d_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            h_next    = '0;
            l_next    = req.opa;
            d_next    = req.opb;
            op_next   = req.op;
            cnt_next  = stpg_pkg::UNIT_CNT_W'(stpg_pkg::UNIT_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (op_reg == stpg_pkg::OP_DIV)
            begin
                h_next = add_sum[ADD_W-1] ? trial[stpg_pkg::WORD_W-1:0]
                                          : add_sum[stpg_pkg::WORD_W-1:0];
                l_next = {l_reg[stpg_pkg::WORD_W-2:0], ~add_sum[ADD_W-1]};
            end
            else
            begin
                h_next = add_sum[stpg_pkg::WORD_W:1];
                l_next = {add_sum[0], l_reg[stpg_pkg::WORD_W-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == stpg_pkg::UNIT_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= stpg_pkg::OP_DIV;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        l_reg <= l_next;
        d_reg <= d_next;
    end

endmodule

[design/stpg_core.sv]
// Sequencer and pattern state: sample timing, read evaluation through the shared unit,
// and the output register. Depends on stpg_pkg, stpg_in_if, stpg_out_if.
`timescale 1ns / 1ps

module stpg_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stpg_pkg::stpg_cfg_t         cfg,
    stpg_in_if.sink                     item,
    stpg_out_if.source                  result,
    output stpg_pkg::stpg_unit_req_t    unit_req,
    input  stpg_pkg::stpg_unit_resp_t   unit_resp
);

    localparam int W  = stpg_pkg::WORD_W;
    localparam int VW = 2 * W + 2;
    localparam logic signed [VW-1:0] SAT_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [VW-1:0] SAT_MIN = -66'sh0_8000_0000;

    stpg_pkg::stpg_state_t          state_reg, state_next;
    logic [stpg_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic signed [W-1:0]            arg_a_reg, arg_a_next;
    logic signed [W-1:0]            arg_b_reg, arg_b_next;
    logic signed [W-1:0]            arg_c_reg, arg_c_next;
    logic                           active_reg, active_next;
    logic [stpg_pkg::PERIOD_W-1:0]  ms_reg, ms_next;
    logic [W-1:0]                   idx_reg, idx_next;
    logic                           read_done_reg, read_done_next;
    logic                           passed_reg, passed_next;
    logic [W-1:0]                   hi1_reg, hi1_next;
    logic [W-1:0]                   lo1_reg, lo1_next;
    logic [W-1:0]                   q2_reg, q2_next;
    logic signed [VW-1:0]           v_reg, v_next;
    logic signed [W-1:0]            smp_reg, smp_next;
    logic                           svalid_reg, svalid_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [W-1:0]            out_sample_reg, out_sample_next;
    logic                           out_svalid_reg, out_svalid_next;
    logic                           out_sready_reg, out_sready_next;
    logic                           out_running_reg, out_running_next;
    logic [W-1:0]                   out_number_reg, out_number_next;

    logic signed [W:0]              w_diff;
    logic                           w_neg;
    logic                           w_pos;
    logic [W:0]                     per_eff;
    logic [W:0]                     ms_inc;
    logic [W+3:0]                   times_ten;
    logic [VW-1:0]                  prod_ext;
    logic signed [VW-1:0]           a_ext;
    logic signed [VW-1:0]           c_ext;
    logic                           flip;
    logic                           ok;
    logic signed [W-1:0]            sat_val;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    assign item.ready           = (state_reg == stpg_pkg::ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.sample        = out_sample_reg;
    assign result.sample_valid  = out_svalid_reg;
    assign result.sample_ready  = out_sready_reg;
    assign result.running       = out_running_reg;
    assign result.sample_number = out_number_reg;

    assign w_diff    = {arg_b_reg[W-1], arg_b_reg} - {arg_a_reg[W-1], arg_a_reg};
    assign w_neg     = w_diff[W];
    assign w_pos     = !w_neg && (w_diff != '0);
    assign per_eff   = (cfg.period == '0) ? (W+1)'(1) : (W+1)'(cfg.period);
    assign ms_inc    = (W+1)'(ms_reg) + 1'b1;
    assign times_ten = (W+4)'({hi1_reg[W-1:3], 3'b000}) + (W+4)'({hi1_reg[W-1:3], 1'b0});
    assign prod_ext  = {2'b00, hi1_reg, lo1_reg};
    assign a_ext     = {{(VW-W){arg_a_reg[W-1]}}, arg_a_reg};
    assign c_ext     = {{(VW-W){arg_c_reg[W-1]}}, arg_c_reg};
    assign flip      = arg_b_reg[W-1] ^ (mode_reg == stpg_pkg::MODE_DEC);

    always_comb
    begin
        if (v_reg > SAT_MAX)
        begin
            sat_val = SAT_MAX[W-1:0];
        end
        else if (v_reg < SAT_MIN)
        begin
            sat_val = SAT_MIN[W-1:0];
        end
        else
        begin
            sat_val = v_reg[W-1:0];
        end
        case (mode_reg) inside
            stpg_pkg::MODE_CONST: ok = !arg_b_reg[W-1] && (idx_reg < q2_reg);
            stpg_pkg::MODE_INC:   ok = (v_reg <= c_ext);
            stpg_pkg::MODE_DEC:   ok = (v_reg >= c_ext);
            default:              ok = !arg_c_reg[W-1] && (idx_reg < q2_reg) && !w_neg;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        arg_a_next       = arg_a_reg;
        arg_b_next       = arg_b_reg;
        arg_c_next       = arg_c_reg;
        active_next      = active_reg;
        ms_next          = ms_reg;
        idx_next         = idx_reg;
        read_done_next   = read_done_reg;
        passed_next      = passed_reg;
        hi1_next         = hi1_reg;
        lo1_next         = lo1_reg;
        q2_next          = q2_reg;
        v_next           = v_reg;
        smp_next         = smp_reg;
        svalid_next      = svalid_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_sample_next  = out_sample_reg;
        out_svalid_next  = out_svalid_reg;
        out_sready_next  = out_sready_reg;
        out_running_next = out_running_reg;
        out_number_next  = out_number_reg;
        unit_req.start   = 1'b0;
        unit_req.op      = stpg_pkg::OP_MUL;
        unit_req.opa     = '0;
        unit_req.opb     = stpg_pkg::RECIP_TEN;

        unique case (state_reg)
            stpg_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    smp_next    = '0;
                    svalid_next = 1'b0;
                    state_next  = stpg_pkg::ST_EMIT;
                    unique case (item.action)
                        stpg_pkg::ACT_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (ms_inc >= per_eff)
                                begin
                                    ms_next     = '0;
                                    idx_next    = idx_reg + 1'b1;
                                    passed_next = 1'b1;
                                end
                                else
                                begin
                                    ms_next = ms_inc[stpg_pkg::PERIOD_W-1:0];
                                end
                            end
                        end
                        stpg_pkg::ACT_READ:
                        begin
                            if (active_reg)
                            begin
                                read_done_next = 1'b1;
                                passed_next    = 1'b0;
                                unit_req.start = 1'b1;
                                state_next     = stpg_pkg::ST_OP1;
                                case (mode_reg) inside
                                    stpg_pkg::MODE_CONST:
                                    begin
                                        unit_req.opa = mag(arg_a_reg);
                                    end
                                    stpg_pkg::MODE_INC, stpg_pkg::MODE_DEC:
                                    begin
                                        unit_req.op  = stpg_pkg::OP_MUL;
                                        unit_req.opa = idx_reg;
                                        unit_req.opb = mag(arg_b_reg);
                                    end
                                    default:
                                    begin
                                        unit_req.op  = stpg_pkg::OP_DIV;
                                        unit_req.opa = item.random_word;
                                        unit_req.opb = w_diff[W-1:0];
                                    end
                                endcase
                            end
                        end
                        stpg_pkg::ACT_START:
                        begin
                            mode_next      = cfg.mode;
                            arg_a_next     = cfg.first;
                            arg_b_next     = cfg.second;
                            arg_c_next     = cfg.third;
                            active_next    = (cfg.mode <= stpg_pkg::MODE_RAND);
                            ms_next        = '0;
                            idx_next       = '0;
                            read_done_next = 1'b0;
                            passed_next    = 1'b0;
                        end
                        default:
                        begin
                            state_next = stpg_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            stpg_pkg::ST_OP1:
            begin
                if (unit_resp.done)
                begin
                    hi1_next = unit_resp.hi;
                    lo1_next = unit_resp.lo;
                    if (mode_reg == stpg_pkg::MODE_INC || mode_reg == stpg_pkg::MODE_DEC)
                    begin
                        state_next = stpg_pkg::ST_SUM;
                    end
                    else
                    begin
                        unit_req.start = 1'b1;
                        unit_req.opa   = (mode_reg == stpg_pkg::MODE_CONST) ? mag(arg_b_reg)
                                                                            : mag(arg_c_reg);
                        state_next     = stpg_pkg::ST_OP2;
                    end
                end
            end
            stpg_pkg::ST_OP2:
            begin
                if (unit_resp.done)
                begin
                    q2_next    = {3'b000, unit_resp.hi[W-1:3]};
                    state_next = stpg_pkg::ST_SUM;
                end
            end
            stpg_pkg::ST_SUM:
            begin
                case (mode_reg) inside
                    stpg_pkg::MODE_CONST:
                    begin
                        v_next = arg_a_reg[W-1] ? -$signed(VW'(times_ten))
                                                : $signed(VW'(times_ten));
                    end
                    stpg_pkg::MODE_INC, stpg_pkg::MODE_DEC:
                    begin
                        v_next = a_ext + (flip ? -$signed(prod_ext) : $signed(prod_ext));
                    end
                    default:
                    begin
                        v_next = a_ext + $signed(VW'(w_pos ? hi1_reg : '0));
                    end
                endcase
                state_next = stpg_pkg::ST_FINISH;
            end
            stpg_pkg::ST_FINISH:
            begin
                if (ok)
                begin
                    smp_next    = sat_val;
                    svalid_next = 1'b1;
                end
                else
                begin
                    smp_next    = '0;
                    svalid_next = 1'b0;
                    active_next = 1'b0;
                end
                state_next = stpg_pkg::ST_EMIT;
            end
            stpg_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_sample_next  = smp_reg;
                    out_svalid_next  = svalid_reg;
                    out_sready_next  = active_reg && (!read_done_reg || passed_reg);
                    out_running_next = active_reg;
                    out_number_next  = idx_reg;
                    state_next       = stpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stpg_pkg::ST_IDLE;
            mode_reg      <= stpg_pkg::MODE_NONE;
            arg_a_reg     <= '0;
            arg_b_reg     <= '0;
            arg_c_reg     <= '0;
            active_reg    <= 1'b0;
            ms_reg        <= '0;
            idx_reg       <= '0;
            read_done_reg <= 1'b0;
            passed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            arg_a_reg     <= arg_a_next;
            arg_b_reg     <= arg_b_next;
            arg_c_reg     <= arg_c_next;
            active_reg    <= active_next;
            ms_reg        <= ms_next;
            idx_reg       <= idx_next;
            read_done_reg <= read_done_next;
            passed_reg    <= passed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi1_reg         <= hi1_next;
        lo1_reg         <= lo1_next;
        q2_reg          <= q2_next;
        v_reg           <= v_next;
        smp_reg         <= smp_next;
        svalid_reg      <= svalid_next;
        out_sample_reg  <= out_sample_next;
        out_svalid_reg  <= out_svalid_next;
        out_sready_reg  <= out_sready_next;
        out_running_reg <= out_running_next;
        out_number_reg  <= out_number_next;
    end

endmodule

[tb/sensor_test_pattern_generator_unit_test.sv]
// Testbench for the sensor test pattern generator top level.
// Drives directed and random start, tick, read and no-op transfers, predicts each result and checks it.
// Depends on stpg_pkg, the three channel interfaces and sensor_test_pattern_generator_unit.
`timescale 1ns / 1ps

module sensor_test_pattern_generator_unit_test;

    localparam int     RANDOM_ITEMS    = 1800;
    localparam int     QUIET_LIMIT     = 3000;
    localparam int     TAIL_CYCLES     = 100;
    localparam longint TENTHS_PER_UNIT = 10;
    localparam longint SAMPLE_MAX      = 64'sd2147483647;
    localparam longint SAMPLE_MIN      = -64'sd2147483648;
    localparam logic [stpg_pkg::WORD_W-1:0] WORD_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [stpg_pkg::WORD_W-1:0] WORD_MIN_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [stpg_pkg::WORD_W-1:0] sample;
        logic                               sample_valid;
        logic                               sample_ready;
        logic                               running;
        logic [stpg_pkg::WORD_W-1:0]        sample_number;
    } sample_report_t;

    logic clk = 1'b0;
    logic rst_n;

    stpg_cfg_if cfg_if ();
    stpg_in_if  item_if ();
    stpg_out_if result_if ();

    sensor_test_pattern_generator_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [stpg_pkg::MODE_W-1:0]          reg_mode   = stpg_pkg::MODE_NONE;
    logic signed [stpg_pkg::WORD_W-1:0]   reg_first  = '0;
    logic signed [stpg_pkg::WORD_W-1:0]   reg_second = '0;
    logic signed [stpg_pkg::WORD_W-1:0]   reg_third  = '0;
    logic [stpg_pkg::PERIOD_W-1:0]        reg_period = stpg_pkg::PERIOD_RESET;

    logic                                 gen_active   = 1'b0;
    logic [stpg_pkg::PERIOD_W-1:0]        ms_count     = '0;
    logic [stpg_pkg::WORD_W-1:0]          gen_index    = '0;
    logic                                 read_seen    = 1'b0;
    logic                                 period_seen  = 1'b0;
    logic [stpg_pkg::MODE_W-1:0]          latched_mode = stpg_pkg::MODE_NONE;
    longint                               lat_first    = 0;
    longint                               lat_second   = 0;
    longint                               lat_third    = 0;

    sample_report_t expected_samples[$];

    int mismatches      = 0;
    int items_sent      = 0;
    int starts_sent     = 0;
    int ticks_sent      = 0;
    int reads_sent      = 0;
    int valid_samples   = 0;
    int register_writes = 0;
    int burst_left      = 0;
    int quiet_cycles    = 0;

    function automatic sample_report_t step_generator(
        input logic [stpg_pkg::ACTION_W-1:0] act,
        input logic [stpg_pkg::WORD_W-1:0] rnd);
        sample_report_t rep;
        longint         idx;
        longint         value;
        longint         span;
        longint         offset;
        logic [stpg_pkg::WORD_W-1:0] per;
        logic [stpg_pkg::WORD_W-1:0] next_count;
        logic           ok;
        rep = '0;
        case (act)
            stpg_pkg::ACT_START:
            begin
                latched_mode = reg_mode;
                lat_first    = reg_first;
                lat_second   = reg_second;
                lat_third    = reg_third;
                gen_active   = (reg_mode <= stpg_pkg::MODE_RAND);
                ms_count     = '0;
                gen_index    = '0;
                read_seen    = 1'b0;
                period_seen  = 1'b0;
            end
            stpg_pkg::ACT_TICK:
            begin
                if (gen_active)
                begin
                    per = (reg_period == '0) ? 32'd1 : {16'd0, reg_period};
                    next_count = {16'd0, ms_count} + 32'd1;
                    if (next_count >= per)
                    begin
                        ms_count    = '0;
                        gen_index   = gen_index + 32'd1;
                        period_seen = 1'b1;
                    end
                    else
                    begin
                        ms_count = next_count[stpg_pkg::PERIOD_W-1:0];
                    end
                end
            end
            stpg_pkg::ACT_READ:
            begin
                if (gen_active)
                begin
                    read_seen   = 1'b1;
                    period_seen = 1'b0;
                    idx = longint'({32'd0, gen_index});
                    case (latched_mode)
                        stpg_pkg::MODE_CONST:
                        begin
                            value = (lat_first / TENTHS_PER_UNIT) * TENTHS_PER_UNIT;
                            ok = idx < (lat_second / TENTHS_PER_UNIT);
                        end
                        stpg_pkg::MODE_INC:
                        begin
                            value = lat_first + lat_second * idx;
                            ok = value <= lat_third;
                        end
                        stpg_pkg::MODE_DEC:
                        begin
                            value = lat_first - lat_second * idx;
                            ok = value >= lat_third;
                        end
                        default:
                        begin
                            span = lat_second - lat_first;
                            offset = 0;
                            if (span > 0)
                                offset = longint'({32'd0, rnd}) % span;
                            value = lat_first + offset;
                            ok = (idx < (lat_third / TENTHS_PER_UNIT)) && (span >= 0);
                        end
                    endcase
                    if (ok)
                    begin
                        if (value > SAMPLE_MAX)
                            value = SAMPLE_MAX;
                        else if (value < SAMPLE_MIN)
                            value = SAMPLE_MIN;
                        rep.sample       = value[stpg_pkg::WORD_W-1:0];
                        rep.sample_valid = 1'b1;
                    end
                    else
                    begin
                        gen_active = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        rep.sample_ready  = gen_active && (!read_seen || period_seen);
        rep.running       = gen_active;
        rep.sample_number = gen_index;
        return rep;
    endfunction

    task automatic send_item(input logic [stpg_pkg::ACTION_W-1:0] act,
                             input logic [stpg_pkg::WORD_W-1:0] rnd);
        sample_report_t rep;
        int             gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_if.valid       <= 1'b1;
        item_if.action      <= act;
        item_if.random_word <= rnd;
        do @(posedge clk); while (!item_if.ready);
        rep = step_generator(act, rnd);
        expected_samples.push_back(rep);
        items_sent++;
        case (act)
            stpg_pkg::ACT_START: starts_sent++;
            stpg_pkg::ACT_TICK:  ticks_sent++;
            stpg_pkg::ACT_READ:  reads_sent++;
            default:   ;
        endcase
        if (rep.sample_valid)
            valid_samples++;
    endtask

    task automatic write_register(input logic [stpg_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [stpg_pkg::WORD_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            stpg_pkg::CFG_MODE:   reg_mode   = data[stpg_pkg::MODE_W-1:0];
            stpg_pkg::CFG_FIRST:  reg_first  = data;
            stpg_pkg::CFG_SECOND: reg_second = data;
            stpg_pkg::CFG_THIRD:  reg_third  = data;
            stpg_pkg::CFG_PERIOD: reg_period = data[stpg_pkg::PERIOD_W-1:0];
            default:    ;
        endcase
        register_writes++;
    endtask

    task automatic close_register_writes();
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain_samples();
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_generator();
        int                               u;
        logic [stpg_pkg::CFG_INDEX_W-1:0] spare_index;
        write_register(stpg_pkg::CFG_MODE, 32'hFFFF_FFFC);
        for (u = int'(stpg_pkg::CFG_PERIOD) + 1; u < (1 << stpg_pkg::CFG_INDEX_W); u++)
        begin
            spare_index = u[stpg_pkg::CFG_INDEX_W-1:0];
            write_register(spare_index, $urandom);
        end
        close_register_writes();
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        send_item(stpg_pkg::ACT_NOP, $urandom);
        send_item(stpg_pkg::ACT_START, $urandom);
        drain_samples();
    endtask

    task automatic test_constant_pattern();
        write_register(stpg_pkg::CFG_MODE, {29'd0, stpg_pkg::MODE_CONST});
        write_register(stpg_pkg::CFG_FIRST, -32'sd1234);
        write_register(stpg_pkg::CFG_SECOND, 32'd25);
        write_register(stpg_pkg::CFG_THIRD, WORD_MIN_NEG);
        write_register(stpg_pkg::CFG_PERIOD, 32'hABCD_0000);
        close_register_writes();
        send_item(stpg_pkg::ACT_START, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        drain_samples();
    endtask

    task automatic test_falling_ramp();
        write_register(stpg_pkg::CFG_MODE, {29'd0, stpg_pkg::MODE_DEC});
        write_register(stpg_pkg::CFG_FIRST, WORD_MAX_POS);
        write_register(stpg_pkg::CFG_SECOND, WORD_MAX_POS);
        write_register(stpg_pkg::CFG_THIRD, 32'd0);
        write_register(stpg_pkg::CFG_PERIOD, 32'd1);
        close_register_writes();
        send_item(stpg_pkg::ACT_START, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        drain_samples();
    endtask

    task automatic test_random_pattern();
        write_register(stpg_pkg::CFG_MODE, {29'd0, stpg_pkg::MODE_RAND});
        write_register(stpg_pkg::CFG_FIRST, WORD_MIN_NEG);
        write_register(stpg_pkg::CFG_SECOND, WORD_MAX_POS);
        write_register(stpg_pkg::CFG_THIRD, 32'd20);
        close_register_writes();
        send_item(stpg_pkg::ACT_START, $urandom);
        send_item(stpg_pkg::ACT_READ, 32'hFFFF_FFFF);
        send_item(stpg_pkg::ACT_READ, 32'h0000_0000);
        drain_samples();
    endtask

    task automatic test_period_change();
        write_register(stpg_pkg::CFG_MODE, {29'd0, stpg_pkg::MODE_INC});
        write_register(stpg_pkg::CFG_FIRST, 32'd0);
        write_register(stpg_pkg::CFG_SECOND, 32'd10);
        write_register(stpg_pkg::CFG_THIRD, 32'd100);
        write_register(stpg_pkg::CFG_PERIOD, 32'hFFFF_0004);
        close_register_writes();
        send_item(stpg_pkg::ACT_START, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_TICK, $urandom);
        drain_samples();
        write_register(stpg_pkg::CFG_PERIOD, 32'd2);
        write_register(stpg_pkg::CFG_MODE, {29'd0, stpg_pkg::MODE_CONST});
        close_register_writes();
        send_item(stpg_pkg::ACT_TICK, $urandom);
        send_item(stpg_pkg::ACT_READ, $urandom);
        drain_samples();
    endtask

    task automatic test_random_sequences();
        int                            target;
        int                            steps;
        int                            split;
        int                            k;
        int                            roll;
        int                            stride;
        int                            base_value;
        int                            step_value;
        int                            limit_value;
        logic [stpg_pkg::MODE_W-1:0]   mode;
        logic [stpg_pkg::PERIOD_W-1:0] period;
        logic [stpg_pkg::ACTION_W-1:0] act;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            drain_samples();
            case ($urandom_range(0, 8))
                0, 1:    mode = stpg_pkg::MODE_CONST;
                2, 3:    mode = stpg_pkg::MODE_INC;
                4, 5:    mode = stpg_pkg::MODE_DEC;
                6, 7:    mode = stpg_pkg::MODE_RAND;
                default: mode = stpg_pkg::MODE_NONE | 3'($urandom_range(0, 3));
            endcase
            stride = int'($urandom_range(0, 300)) - 60;
            base_value = int'($urandom_range(0, 4000)) - 2000;
            case (mode)
                stpg_pkg::MODE_CONST:
                begin
                    step_value = int'($urandom_range(0, 120)) - 20;
                    limit_value = $urandom;
                end
                stpg_pkg::MODE_INC:
                begin
                    step_value = stride;
                    limit_value = base_value + stride * int'($urandom_range(0, 10))
                                  + int'($urandom_range(0, 9));
                end
                stpg_pkg::MODE_DEC:
                begin
                    step_value = stride;
                    limit_value = base_value - stride * int'($urandom_range(0, 10))
                                  - int'($urandom_range(0, 9));
                end
                stpg_pkg::MODE_RAND:
                begin
                    step_value = base_value + int'($urandom_range(0, 500)) - 20;
                    limit_value = int'($urandom_range(0, 150)) - 10;
                end
                default:
                begin
                    step_value = $urandom;
                    limit_value = $urandom;
                end
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                base_value = $urandom;
                step_value = $urandom;
            end
            case ($urandom_range(0, 11))
                0:       period = 16'hFFFF;
                1:       period = '0;
                2:       period = 16'($urandom);
                default: period = 16'($urandom_range(1, 4));
            endcase
            write_register(stpg_pkg::CFG_MODE, ($urandom & 32'hFFFF_FFF8) | {29'd0, mode});
            if ($urandom_range(0, 7) != 0)
                write_register(stpg_pkg::CFG_FIRST, base_value);
            if ($urandom_range(0, 7) != 0)
                write_register(stpg_pkg::CFG_SECOND, step_value);
            if ($urandom_range(0, 7) != 0)
                write_register(stpg_pkg::CFG_THIRD, limit_value);
            if ($urandom_range(0, 7) != 0)
                write_register(stpg_pkg::CFG_PERIOD,
                               ($urandom & 32'hFFFF_0000) | {16'd0, period});
            close_register_writes();
            send_item(stpg_pkg::ACT_START, $urandom);
            steps = $urandom_range(4, 40);
            split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, steps - 1) : -1;
            for (k = 0; k < steps; k++)
            begin
                if (k == split)
                begin
                    drain_samples();
                    write_register(stpg_pkg::CFG_PERIOD, $urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 0)
                        write_register(stpg_pkg::CFG_FIRST, $urandom);
                    close_register_writes();
                end
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    act = stpg_pkg::ACT_TICK;
                else if (roll < 90)
                    act = stpg_pkg::ACT_READ;
                else if (roll < 95)
                    act = stpg_pkg::ACT_NOP;
                else
                    act = stpg_pkg::ACT_START;
                send_item(act, $urandom);
            end
        end
        drain_samples();
    endtask

    initial
    begin
        int hold;
        int style;
        int phase;
        hold = 0;
        style = 0;
        phase = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                style = $urandom_range(0, 3);
                hold = $urandom_range(20, 200);
            end
            hold--;
            phase++;
            case (style)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= 1'($urandom_range(0, 1));
                2:       result_if.ready <= ($urandom_range(0, 3) == 0);
                default: result_if.ready <= (phase % 6 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        sample_report_t expected;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("result: transfer with no expectation waiting, sample %0d",
                       result_if.sample);
                mismatches++;
            end
            else
            begin
                expected = expected_samples.pop_front();
                if (result_if.sample !== expected.sample)
                begin
                    $error("sample: expected %0d, got %0d", expected.sample, result_if.sample);
                    mismatches++;
                end
                if (result_if.sample_valid !== expected.sample_valid)
                begin
                    $error("sample_valid: expected %0d, got %0d", expected.sample_valid,
                           result_if.sample_valid);
                    mismatches++;
                end
                if (result_if.sample_ready !== expected.sample_ready)
                begin
                    $error("sample_ready: expected %0d, got %0d", expected.sample_ready,
                           result_if.sample_ready);
                    mismatches++;
                end
                if (result_if.running !== expected.running)
                begin
                    $error("running: expected %0d, got %0d", expected.running,
                           result_if.running);
                    mismatches++;
                end
                if (result_if.sample_number !== expected.sample_number)
                begin
                    $error("sample_number: expected %0d, got %0d", expected.sample_number,
                           result_if.sample_number);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        item_if.valid       <= 1'b0;
        item_if.action      <= stpg_pkg::ACT_NOP;
        item_if.random_word <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= stpg_pkg::CFG_MODE;
        cfg_if.data         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_generator();
        test_constant_pattern();
        test_falling_ramp();
        test_random_pattern();
        test_period_change();
        test_random_sequences();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d transfers: %0d starts, %0d ticks, %0d reads (%0d valid samples).",
                 items_sent, starts_sent, ticks_sent, reads_sent, valid_samples);
        $display("Register writes: %0d, mismatches: %0d.", register_writes, mismatches);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sensor_test_pattern_generator_unit.f]
design/stpg_pkg.sv
design/stpg_in_if.sv
design/stpg_out_if.sv
design/stpg_cfg_if.sv
design/stpg_cfg_regs.sv
design/stpg_iter_unit.sv
design/stpg_core.sv
design/sensor_test_pattern_generator_unit.sv
tb/sensor_test_pattern_generator_unit_test.sv
